@@ rtl/core/mlv_pkg.sv @@
// Shared widths, constants, register indexes and saturation helpers for the
// mixing-length turbulent viscosity block. No dependencies.
package mlv_pkg;

	localparam int W = 48;          // word width, signed gradient fields
	localparam int F = 24;          // fraction bits
	localparam int V = W - 1;       // unsigned value width
	localparam int H = W / 2;       // partial product split
	localparam int P = 2 * W;       // full product width

	localparam logic [V-1:0] VAL_MAX = {V{1'b1}};
	localparam logic [W-1:0] THREE_TENTHS_Q32 = W'(32'd1288490189);

	typedef enum logic [1:0] {
		REG_SOLIDUS  = 2'd0,
		REG_PR_RECIP = 2'd1,
		REG_MIN_NORM = 2'd2,
		REG_DIMS     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [V-1:0] temp;
		logic [V-1:0] rho;
		logic [V-1:0] mu;
		logic [V-1:0] cp;
		logic [V-1:0] tv;
	} side_t;

	// (p >> F), clamped to the value range
	function automatic logic [V-1:0] sat_frac(input logic [P-1:0] p);
		if (|p[P-1:F+V])
			return VAL_MAX;
		return p[F+V-1:F];
	endfunction

	// (p >> 32), clamped to the value range
	function automatic logic [V-1:0] sat_q32(input logic [P-1:0] p);
		if (|p[P-1:32+V])
			return VAL_MAX;
		return p[32+V-1:32];
	endfunction

endpackage

@@ rtl/core/mlv_mul.sv @@
// Two-stage unsigned word multiplier built from four half-width partial products.
// Depends on mlv_pkg.
module mlv_mul import mlv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	input  side_t        in_side,
	output logic         out_valid,
	output logic [P-1:0] prod,
	output side_t        out_side
);

	logic [W-1:0] pp_ll_s1, pp_lh_s1, pp_hl_s1, pp_hh_s1;
	logic         vld_s1;
	side_t        side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1    <= in_valid;
			out_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pp_ll_s1 <= W'(a[H-1:0]) * W'(b[H-1:0]);
		pp_lh_s1 <= W'(a[H-1:0]) * W'(b[W-1:H]);
		pp_hl_s1 <= W'(a[W-1:H]) * W'(b[H-1:0]);
		pp_hh_s1 <= W'(a[W-1:H]) * W'(b[W-1:H]);
		side_s1  <= in_side;
		prod     <= {pp_hh_s1, pp_ll_s1}
			+ (P'(pp_lh_s1) << H) + (P'(pp_hl_s1) << H);
		out_side <= side_s1;
	end

endmodule

@@ rtl/core/mlv_sqrt.sv @@
// Pipelined integer square root, one root bit per stage over the full product.
// Depends on mlv_pkg.
module mlv_sqrt import mlv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [P-1:0] sq,
	input  side_t        in_side,
	output logic         out_valid,
	output logic [W-1:0] root,
	output side_t        out_side
);

	// one stage per root bit: W stages over the P-bit radicand
	logic         vld_s  [0:W];
	logic [W+1:0] rem_s  [0:W];
	logic [W-1:0] root_s [0:W];
	logic [P-1:0] rest_s [0:W];
	side_t        side_s [0:W];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rest_s[0] = sq;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic [W+3:0] rem_sh, trial, diff;
		logic         ge;

		assign rem_sh = {rem_s[k], rest_s[k][P-1:P-2]};
		assign trial  = {2'b00, root_s[k], 2'b01};
		assign ge     = rem_sh >= trial;
		assign diff   = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[W+1:0] : rem_sh[W+1:0];
			root_s[k+1] <= {root_s[k][W-2:0], ge};
			rest_s[k+1] <= {rest_s[k][P-3:0], 2'b00};
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[W];
	assign root      = root_s[W];
	assign out_side  = side_s[W];

`ifndef ASSERT_OFF
	// floor root leaves a remainder of at most twice the root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[W] |-> rem_s[W] <= {1'b0, root_s[W], 1'b0})
		else $error("sqrt remainder out of range");
`endif

endmodule

@@ rtl/core/mlv_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with zero and
// saturation overrides on the result. Depends on mlv_pkg.
module mlv_div import mlv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] divisor,
	input  logic [W-1:0] rem_init,
	input  logic [V-1:0] num_bits,
	input  logic         force_zero,
	input  logic         force_max,
	input  side_t        in_side,
	output logic         out_valid,
	output logic [V-1:0] y,
	output side_t        out_side
);

	logic         vld_s  [0:V];
	logic [W-1:0] rem_s  [0:V];
	logic [W-1:0] dvr_s  [0:V];
	logic [V-1:0] bits_s [0:V];
	logic [V-1:0] quo_s  [0:V];
	logic         zero_s [0:V];
	logic         max_s  [0:V];
	side_t        side_s [0:V];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = rem_init;
	assign dvr_s[0]  = divisor;
	assign bits_s[0] = num_bits;
	assign quo_s[0]  = '0;
	assign zero_s[0] = force_zero;
	assign max_s[0]  = force_max;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < V; k++) begin : g_stage
		logic [W:0] r2, diff;
		logic       ge;

		assign r2   = {rem_s[k], bits_s[k][V-1]};
		assign ge   = r2 >= {1'b0, dvr_s[k]};
		assign diff = r2 - {1'b0, dvr_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? diff[W-1:0] : r2[W-1:0];
			quo_s[k+1]  <= {quo_s[k][V-2:0], ge};
			bits_s[k+1] <= {bits_s[k][V-2:0], 1'b0};
			dvr_s[k+1]  <= dvr_s[k];
			zero_s[k+1] <= zero_s[k];
			max_s[k+1]  <= max_s[k];
			side_s[k+1] <= side_s[k];
		end
	end

	assign out_valid = vld_s[V];
	assign out_side  = side_s[V];
	assign y = zero_s[V] ? '0 : (max_s[V] ? VAL_MAX : quo_s[V]);

`ifndef ASSERT_OFF
	// a fitting quotient always leaves a remainder below the divisor
	a_rem_lt_dvr: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[V] && !zero_s[V] && !max_s[V]) |-> rem_s[V] < dvr_s[V])
		else $error("divider remainder not below divisor");
`endif

endmodule

@@ rtl/core/mixing_length_turbulent_viscosity.sv @@
// A new request every cycle; done rises for each start request.
// Depth: input register, squaring (2), sum register, square root (48 stages),
// divider set-up (1), divider (47), five two-stage multipliers each followed
// by a saturation or output register (15). Results appear for one cycle with
// done; the receiver cannot stall. Reset (arst_n low) empties the pipeline
// and loads register defaults.
module mixing_length_turbulent_viscosity import mlv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [V-1:0] cfg_data,
	input  logic [W-1:0] grad_x,
	input  logic [W-1:0] grad_y,
	input  logic [W-1:0] grad_z,
	input  logic [V-1:0] node_temperature,
	input  logic [V-1:0] node_density,
	input  logic [V-1:0] molecular_viscosity,
	input  logic [V-1:0] heat_capacity,
	output logic         done,
	output logic [V-1:0] eddy_viscosity,
	output logic [V-1:0] eddy_conductivity
);

	logic [V-1:0] solidus_q, pr_recip_q, min_norm_q;
	logic [1:0]   dims_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solidus_q  <= V'(64'd1000) << F;
			pr_recip_q <= V'(64'd1) << F;
			min_norm_q <= V'(64'd1);
			dims_q     <= 2'd3;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_SOLIDUS:  solidus_q  <= cfg_data;
				REG_PR_RECIP: pr_recip_q <= cfg_data;
				REG_MIN_NORM: min_norm_q <= cfg_data;
				REG_DIMS:     dims_q     <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// magnitudes; drop the third component in two dimensions
	logic         vld_s1;
	logic [W-1:0] gx_s1, gy_s1, gz_s1;
	side_t        side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		gx_s1 <= grad_x[W-1] ? -grad_x : grad_x;
		gy_s1 <= grad_y[W-1] ? -grad_y : grad_y;
		gz_s1 <= (dims_q == 2'd2) ? '0 : (grad_z[W-1] ? -grad_z : grad_z);
		side_s1 <= '{temp: node_temperature, rho: node_density,
			mu: molecular_viscosity, cp: heat_capacity, tv: '0};
	end

	logic         vld_s3;
	logic [P-1:0] px_s3, py_s3, pz_s3;
	side_t        side_s3;

	mlv_mul u_sqx (.clk, .arst_n, .in_valid(vld_s1), .a(gx_s1), .b(gx_s1),
		.in_side(side_s1), .out_valid(vld_s3), .prod(px_s3), .out_side(side_s3));
	mlv_mul u_sqy (.clk, .arst_n, .in_valid(vld_s1), .a(gy_s1), .b(gy_s1),
		.in_side(side_s1), .out_valid(), .prod(py_s3), .out_side());
	mlv_mul u_sqz (.clk, .arst_n, .in_valid(vld_s1), .a(gz_s1), .b(gz_s1),
		.in_side(side_s1), .out_valid(), .prod(pz_s3), .out_side());

	logic         vld_s4;
	logic [P-1:0] sq_s4;
	side_t        side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		sq_s4   <= px_s3 + py_s3 + pz_s3;
		side_s4 <= side_s3;
	end

	logic         vld_rt;
	logic [W-1:0] norm_rt;
	side_t        side_rt;

	mlv_sqrt u_sqrt (.clk, .arst_n, .in_valid(vld_s4), .sq(sq_s4), .in_side(side_s4),
		.out_valid(vld_rt), .root(norm_rt), .out_side(side_rt));

	// distance set-up: zero and overflow decisions, first partial remainder
	logic         vld_s5, zero_s5, ovf_s5;
	logic [W-1:0] norm_s5, rem0_s5;
	logic [V-1:0] bits_s5;
	side_t        side_s5;
	logic [V-1:0] diff_c;
	logic [W-1:0] hi_c;

	assign diff_c = side_rt.temp - solidus_q;
	assign hi_c   = W'(diff_c[V-1:V-F]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_rt;
		end
	end

	always_ff @(posedge clk) begin
		zero_s5 <= (norm_rt == '0) || (norm_rt < {1'b0, min_norm_q})
			|| (side_rt.temp <= solidus_q);
		ovf_s5  <= hi_c >= norm_rt;
		norm_s5 <= norm_rt;
		rem0_s5 <= hi_c;
		bits_s5 <= {diff_c[V-F-1:0], {F{1'b0}}};
		side_s5 <= side_rt;
	end

	logic         vld_y;
	logic [V-1:0] y_dv;
	side_t        side_y;

	mlv_div u_div (.clk, .arst_n, .in_valid(vld_s5), .divisor(norm_s5), .rem_init(rem0_s5),
		.num_bits(bits_s5), .force_zero(zero_s5), .force_max(ovf_s5), .in_side(side_s5),
		.out_valid(vld_y), .y(y_dv), .out_side(side_y));

	// product chain: rho*y, *mu, *0.3, *cp, *1/Pr
	logic         vm1, vm2, vm3, vm4, vm5;
	logic [P-1:0] pm1, pm2, pm3, pm4, pm5;
	side_t        sm1, sm2, sm3, sm4, sm5;
	logic         va_s6, vb_s7, vt_s8, vc_s9;
	logic [V-1:0] a_s6, b_s7, tv_s8, c_s9;
	side_t        sa_s6, sb_s7, st_s8, sc_s9;
	logic [V-1:0] tv_d1_q, tv_s8_d;

	mlv_mul u_m1 (.clk, .arst_n, .in_valid(vld_y), .a({1'b0, side_y.rho}), .b({1'b0, y_dv}),
		.in_side(side_y), .out_valid(vm1), .prod(pm1), .out_side(sm1));
	mlv_mul u_m2 (.clk, .arst_n, .in_valid(va_s6), .a({1'b0, a_s6}), .b({1'b0, sa_s6.mu}),
		.in_side(sa_s6), .out_valid(vm2), .prod(pm2), .out_side(sm2));
	mlv_mul u_m3 (.clk, .arst_n, .in_valid(vb_s7), .a({1'b0, b_s7}), .b(THREE_TENTHS_Q32),
		.in_side(sb_s7), .out_valid(vm3), .prod(pm3), .out_side(sm3));
	mlv_mul u_m4 (.clk, .arst_n, .in_valid(vt_s8), .a({1'b0, tv_s8}), .b({1'b0, st_s8.cp}),
		.in_side(st_s8), .out_valid(vm4), .prod(pm4), .out_side(sm4));
	mlv_mul u_m5 (.clk, .arst_n, .in_valid(vc_s9), .a({1'b0, c_s9}), .b({1'b0, pr_recip_q}),
		.in_side(sc_s9), .out_valid(vm5), .prod(pm5), .out_side(sm5));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_s6 <= 1'b0;
			vb_s7 <= 1'b0;
			vt_s8 <= 1'b0;
			vc_s9 <= 1'b0;
			done  <= 1'b0;
		end else begin
			va_s6 <= vm1;
			vb_s7 <= vm2;
			vt_s8 <= vm3;
			vc_s9 <= vm4;
			done  <= vm5;
		end
	end

	always_ff @(posedge clk) begin
		a_s6  <= sat_frac(pm1);
		sa_s6 <= sm1;
		b_s7  <= sat_frac(pm2);
		sb_s7 <= sm2;
		tv_s8 <= sat_q32(pm3);
		st_s8 <= sm3;
		c_s9  <= sat_frac(pm4);
		sc_s9 <= '{temp: sm4.temp, rho: sm4.rho, mu: sm4.mu, cp: sm4.cp, tv: tv_s8_d};
		eddy_viscosity    <= sm5.tv;
		eddy_conductivity <= sat_frac(pm5);
	end

	// hold tvisc alongside its own conductivity product
	always_ff @(posedge clk) begin
		tv_d1_q <= tv_s8;
		tv_s8_d <= tv_d1_q;
	end

`ifndef ASSERT_OFF
	// no viscosity means no conductivity
	a_zero_cond: assert property (@(posedge clk) disable iff (!arst_n)
		(done && eddy_viscosity == '0) |-> eddy_conductivity == '0)
		else $error("conductivity without viscosity");
	// the carried viscosity matches the one computed for the same node
	a_tv_align: assert property (@(posedge clk) disable iff (!arst_n)
		(vc_s9 && $past(vt_s8, 3)) |-> sc_s9.tv == $past(tv_s8, 3))
		else $error("viscosity misaligned in product chain");
	// busy is never raised, so every valid start enters the pipeline
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> vld_s1)
		else $error("request not taken");
`endif

endmodule

@@ verif/tb.sv @@
// Self-checking testbench for mixing_length_turbulent_viscosity: a bit-exact
// predictor checks every result, with directed and random nodes over several settings.
// Depends on rtl/core/mlv_pkg.sv and the block itself.
`timescale 1ns / 100ps

module tb;
	import mlv_pkg::*;

	localparam logic [31:0] POINT_THREE_Q32 = 32'd1288490189;
	localparam int DRAIN_CYCLES = 140;

	typedef struct packed {
		logic [W-1:0] gx;
		logic [W-1:0] gy;
		logic [W-1:0] gz;
		logic [V-1:0] temp;
		logic [V-1:0] rho;
		logic [V-1:0] mu;
		logic [V-1:0] cp;
	} node_t;

	typedef struct packed {
		logic [V-1:0] tv;
		logic [V-1:0] tc;
	} visc_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	reg_idx_t cfg_index = REG_SOLIDUS;
	logic [V-1:0] cfg_data = '0;
	node_t drv = '0;
	logic done;
	logic [V-1:0] eddy_viscosity;
	logic [V-1:0] eddy_conductivity;

	node_t pending_nodes[$];
	visc_t expected_visc[$];
	int idle_pct = 0;
	int errors = 0;

	// shadow copy of the registers
	logic [V-1:0] solidus = V'(64'd1000 << F);
	logic [V-1:0] pr_recip = V'(64'd1 << F);
	logic [V-1:0] min_norm = V'(1);
	logic [1:0] dims = 2'd3;

	mixing_length_turbulent_viscosity dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.grad_x(drv.gx), .grad_y(drv.gy), .grad_z(drv.gz),
		.node_temperature(drv.temp), .node_density(drv.rho),
		.molecular_viscosity(drv.mu), .heat_capacity(drv.cp),
		.done(done), .eddy_viscosity(eddy_viscosity),
		.eddy_conductivity(eddy_conductivity)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [V-1:0] clamp(input logic [127:0] v);
		return (v > 128'(VAL_MAX)) ? VAL_MAX : v[V-1:0];
	endfunction

	function automatic logic [V-1:0] fix_mul(input logic [V-1:0] a, input logic [V-1:0] b);
		logic [127:0] p;
		p = (128'(a) * 128'(b)) >> F;
		return clamp(p);
	endfunction

	function automatic logic [W-1:0] abs_grad(input logic [W-1:0] g);
		return g[W-1] ? -g : g;
	endfunction

	function automatic visc_t mixing_length_visc(input node_t n);
		logic [W-1:0] mx, my, mz;
		logic [97:0] sq;
		logic [48:0] root, cand;
		logic [127:0] q;
		logic [V-1:0] y, a, b;
		visc_t r;
		mx = abs_grad(n.gx);
		my = abs_grad(n.gy);
		mz = abs_grad(n.gz);
		sq = 98'(mx) * 98'(mx) + 98'(my) * 98'(my);
		if (dims != 2'd2)
			sq = sq + 98'(mz) * 98'(mz);
		root = '0;
		for (int i = 48; i >= 0; i--) begin
			cand = root | (49'd1 << i);
			if (98'(cand) * 98'(cand) <= sq)
				root = cand;
		end
		y = '0;
		if (root != 0 && root >= 49'(min_norm) && n.temp > solidus) begin
			q = (128'(n.temp - solidus) << F) / 128'(root);
			y = clamp(q);
		end
		a = fix_mul(n.rho, y);
		b = fix_mul(a, n.mu);
		r.tv = clamp((128'(b) * 128'(POINT_THREE_Q32)) >> 32);
		r.tc = fix_mul(fix_mul(r.tv, n.cp), pr_recip);
		return r;
	endfunction

	// random value with a random number of leading zeros
	function automatic logic [W-1:0] rand_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return W'(r) >> $urandom_range(0, W - 1);
	endfunction

	function automatic logic [W-1:0] rand_grad();
		logic [W-1:0] m;
		m = rand_word() >> 1;
		if ($urandom_range(0, 9) == 0)
			m = W'({$urandom, $urandom});
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic node_t rand_node();
		node_t n;
		logic [V-1:0] t;
		n.gx = rand_grad();
		n.gy = rand_grad();
		n.gz = rand_grad();
		case ($urandom_range(0, 3))
			0: t = V'(rand_word());
			1: t = solidus + (V'(rand_word()) >> $urandom_range(0, 30));
			2: t = solidus - V'($urandom_range(0, 3));
			default: t = solidus + V'($urandom_range(0, 3));
		endcase
		n.temp = t;
		n.rho = V'(rand_word());
		n.mu = V'(rand_word());
		n.cp = V'(rand_word());
		return n;
	endfunction

	task automatic write_reg(input reg_idx_t idx, input logic [V-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SOLIDUS: solidus = val;
			REG_PR_RECIP: pr_recip = val;
			REG_MIN_NORM: min_norm = val;
			default: dims = val[1:0];
		endcase
	endtask

	task automatic wait_idle();
		while (pending_nodes.size() != 0 || expected_visc.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (start && !busy) begin
			expected_visc.push_back(mixing_length_visc(drv));
			void'(pending_nodes.pop_front());
		end
		if (!(start && busy)) begin
			if (pending_nodes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				start <= 1'b1;
				drv <= pending_nodes[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		visc_t e;
		if (done) begin
			if (expected_visc.size() == 0) begin
				$display("%0t: unexpected result tv=%h tc=%h", $time,
					eddy_viscosity, eddy_conductivity);
				errors++;
			end else begin
				e = expected_visc.pop_front();
				if (eddy_viscosity !== e.tv) begin
					$display("%0t: eddy_viscosity expected %h actual %h", $time,
						e.tv, eddy_viscosity);
					errors++;
				end
				if (eddy_conductivity !== e.tc) begin
					$display("%0t: eddy_conductivity expected %h actual %h", $time,
						e.tc, eddy_conductivity);
					errors++;
				end
			end
		end
	end

	initial begin
		node_t n;
		logic [W-1:0] gmin;
		gmin = {1'b1, {(W-1){1'b0}}};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed nodes at reset settings
		n = '{gx: W'(1), gy: '0, gz: '0, temp: VAL_MAX, rho: VAL_MAX, mu: VAL_MAX,
			cp: VAL_MAX};
		pending_nodes.push_back(n);                // huge distance, all saturate
		n.gx = '0;
		pending_nodes.push_back(n);                // zero norm
		n.gx = gmin; n.gy = gmin; n.gz = gmin;
		pending_nodes.push_back(n);                // most negative gradients
		n.gx = {1'b0, VAL_MAX}; n.gy = {1'b0, VAL_MAX}; n.gz = {1'b0, VAL_MAX};
		pending_nodes.push_back(n);
		n = '{gx: W'(3) << F, gy: -(W'(4) << F), gz: '0, temp: solidus, rho: V'(1) << F,
			mu: V'(1) << F, cp: V'(1) << F};
		pending_nodes.push_back(n);                // exactly at solidus
		n.temp = solidus + 1;
		pending_nodes.push_back(n);
		n.temp = solidus + (V'(10) << F);
		pending_nodes.push_back(n);
		n.gx = '0; n.gy = '0; n.gz = W'(2) << F;
		pending_nodes.push_back(n);                // z only
		n.rho = '0;
		pending_nodes.push_back(n);
		n.rho = VAL_MAX; n.mu = '0;
		pending_nodes.push_back(n);
		n.mu = V'(5) << F; n.cp = '0;
		pending_nodes.push_back(n);
		n.temp = '0;
		pending_nodes.push_back(n);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_reg(REG_SOLIDUS, '0); write_reg(REG_PR_RECIP, VAL_MAX);
					write_reg(REG_MIN_NORM, '0); write_reg(REG_DIMS, V'(2));
				end
				1: begin
					write_reg(REG_SOLIDUS, VAL_MAX); write_reg(REG_PR_RECIP, '0);
					write_reg(REG_MIN_NORM, VAL_MAX); write_reg(REG_DIMS, V'(0));
				end
				2: begin
					write_reg(REG_SOLIDUS, V'(1000) << F);
					write_reg(REG_PR_RECIP, V'(rand_word()));
					write_reg(REG_MIN_NORM, V'(1) << 20); write_reg(REG_DIMS, V'(1));
				end
				3: begin
					write_reg(REG_SOLIDUS, V'(rand_word()));
					write_reg(REG_PR_RECIP, V'(1) << F);
					write_reg(REG_MIN_NORM, V'(1)); write_reg(REG_DIMS, V'(3));
				end
				4: begin
					write_reg(REG_SOLIDUS, V'(300) << F);
					write_reg(REG_PR_RECIP, V'(rand_word()) >> 10);
					write_reg(REG_MIN_NORM, '0); write_reg(REG_DIMS, V'(2));
				end
				default: begin
					write_reg(REG_SOLIDUS, V'(1) << F);
					write_reg(REG_PR_RECIP, V'(13421773)); // about 0.8
					write_reg(REG_MIN_NORM, V'(1) << F); write_reg(REG_DIMS, V'(3));
				end
			endcase
			case (ph % 3)
				0: idle_pct = 0;
				1: idle_pct = 61;
				default: idle_pct = 13;
			endcase
			if (ph == 1) begin
				n = '{gx: W'(1), gy: '0, gz: '0, temp: VAL_MAX, rho: VAL_MAX,
					mu: VAL_MAX, cp: VAL_MAX};
				pending_nodes.push_back(n);
			end
			for (int k = 0; k < 300; k++) begin
				pending_nodes.push_back(rand_node());
				// hold the feed back now and then so bursts and gaps alternate
				if (k % 100 == 50)
					while (pending_nodes.size() != 0) @(posedge clk);
			end
			wait_idle();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ mixing_length_turbulent_viscosity.f @@
rtl/core/mlv_pkg.sv
rtl/core/mlv_mul.sv
rtl/core/mlv_sqrt.sv
rtl/core/mlv_div.sv
rtl/core/mixing_length_turbulent_viscosity.sv
verif/tb.sv
